// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the bit packer.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VWBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VWBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vwbp_pkg.sv =====
// Shared types and constants of the variable-width bit packer.
// Used by every RTL module and the checker; depends on nothing.
package vwbp_pkg;

    localparam int WORD_BITS   = 64;
    localparam int FILL_W      = 7;   // holds 0..64
    localparam int NBYTES_W    = 4;   // holds 0..8
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [FILL_W-1:0] KEY_SIZE_RESET  = 7'd8;
    localparam logic              BIT_ORDER_RESET = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_ORDER = 1'd1;

    // Input commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // Result kinds
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [WORD_BITS-1:0] code_value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] out_data;
        logic                 out_kind;
        logic                 out_last;
    } out_item_t;

    // Job handed from the front to the back: a finished word or a flush.
    typedef struct packed {
        logic                 is_flush;
        logic [WORD_BITS-1:0] data;
        logic [NBYTES_W-1:0]  nbytes;
    } job_t;

endpackage

// ===== rtl/vwbp_front.sv =====
// Front of the bit packer: configuration registers, packing word and fill.
// Accepts items and turns them into jobs for the queue. Depends on vwbp_pkg.
module vwbp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             queue_full,
    input  vwbp_pkg::in_item_t               item,
    input  logic                             cfg_valid,
    input  logic [vwbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vwbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             job_valid,
    output vwbp_pkg::job_t                   job
);
    import vwbp_pkg::*;

    logic [FILL_W-1:0]    key_size_reg;
    logic                 bit_order_reg;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;

    logic                 accept;
    logic [FILL_W-1:0]    key_eff;
    logic [FILL_W:0]      fill_sum;
    logic                 fits;
    logic [FILL_W-1:0]    avail;
    logic [WORD_BITS-1:0] add_term;
    logic [WORD_BITS-1:0] word_add;
    logic [WORD_BITS-1:0] spill;
    logic [FILL_W:0]      byte_round;
    logic [NBYTES_W-1:0]  nbytes;

    assign accept = push && !queue_full;

    always_comb
    begin
        if (key_size_reg == '0)
            key_eff = FILL_W'(1);
        else if (key_size_reg > FILL_W'(WORD_BITS))
            key_eff = FILL_W'(WORD_BITS);
        else
            key_eff = key_size_reg;
    end

    assign fill_sum   = {1'b0, fill_reg} + {1'b0, key_eff};
    assign fits       = fill_sum <= (FILL_W+1)'(WORD_BITS);
    assign avail      = FILL_W'(WORD_BITS) - fill_reg;
    // Shifts of 64 or more yield zero, so a full word takes nothing more.
    assign add_term   = bit_order_reg ? (item.code_value << fill_reg)
                                      : (item.code_value >> fill_reg);
    assign word_add   = word_reg + add_term;
    assign spill      = bit_order_reg ? (item.code_value >> avail)
                                      : (item.code_value << avail);
    assign byte_round = {1'b0, fill_reg} + (FILL_W+1)'(7);
    assign nbytes     = byte_round[FILL_W-1:3];

    always_comb
    begin
        word_next    = word_reg;
        fill_next    = fill_reg;
        job_valid    = 1'b0;
        job.is_flush = 1'b0;
        job.data     = word_add;
        job.nbytes   = nbytes;
        if (accept)
        begin
            if (item.cmd == CMD_CLOSE)
            begin
                job_valid    = nbytes != '0;
                job.is_flush = 1'b1;
                job.data     = word_reg;
                word_next    = '0;
                fill_next    = '0;
            end
            else if (fits)
            begin
                word_next = word_add;
                fill_next = fill_sum[FILL_W-1:0];
            end
            else
            begin
                // Emit the topped-up word and start over with the spilled bits.
                job_valid = 1'b1;
                word_next = spill;
                fill_next = key_eff - avail;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg  <= KEY_SIZE_RESET;
            bit_order_reg <= BIT_ORDER_RESET;
            word_reg      <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_KEY_SIZE)
                key_size_reg <= cfg_data[FILL_W-1:0];
            if (cfg_valid && cfg_index == REG_BIT_ORDER)
                bit_order_reg <= cfg_data[0];
            word_reg <= word_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== rtl/vwbp_queue.sv =====
// Short job queue between the front and the back of the bit packer.
// Depends on vwbp_pkg for the job type.
module vwbp_queue #(
    parameter int DEPTH = vwbp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  vwbp_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output logic           head_valid,
    output vwbp_pkg::job_t head_job
);
    import vwbp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/vwbp_back.sv =====
// Back of the bit packer: turns queued jobs into results, one per cycle while
// they are popped, and holds them in the output register. Depends on vwbp_pkg.
module vwbp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  vwbp_pkg::job_t      head_job,
    output logic                rd_en,
    output logic                empty,
    input  logic                pop,
    output vwbp_pkg::out_item_t result
);
    import vwbp_pkg::*;

    logic      [2:0]          byte_idx_reg, byte_idx_next;
    logic                     out_valid_reg;
    out_item_t                out_item_reg;
    out_item_t                gen_item;
    logic                     taken;
    logic                     load;
    logic                     last_byte;
    logic      [2:0]          byte_sel;

    assign taken     = pop && out_valid_reg;
    assign load      = head_valid && (!out_valid_reg || taken);
    assign last_byte = ({1'b0, byte_idx_reg} + NBYTES_W'(1)) == head_job.nbytes;
    // Byte 0 is the top byte of the word.
    assign byte_sel  = ~byte_idx_reg;

    always_comb
    begin
        gen_item      = '0;
        rd_en         = 1'b0;
        byte_idx_next = byte_idx_reg;
        if (head_job.is_flush)
        begin
            gen_item.out_data[7:0] = head_job.data[{byte_sel, 3'b000} +: 8];
            gen_item.out_kind      = KIND_BYTE;
            gen_item.out_last      = last_byte;
            if (load)
            begin
                rd_en         = last_byte;
                byte_idx_next = last_byte ? 3'd0 : byte_idx_reg + 3'd1;
            end
        end
        else
        begin
            gen_item.out_data = head_job.data;
            gen_item.out_kind = KIND_WORD;
            rd_en             = load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= gen_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            byte_idx_reg  <= '0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (taken)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_item_reg;

endmodule

// ===== rtl/variable_width_bit_packer.sv =====
// Variable-width bit packer: 64-bit word packing of fixed-size codes.
// Channels: items go in through push/full, results come out through empty/pop,
// and a config write channel (cfg_valid/cfg_ready, always ready) sets
// key_size (index 0) and bit_order (index 1).
// A push adds one code at the fill position; when the word overflows, the
// completed word is emitted and the spilled bits start the next word.
// A close emits ceil(fill/8) bytes from the top of the word, last one marked.
// Throughput: one item per cycle while full is low. A word result goes to the
// result ports through the queue and the output register: the front writes
// the job into the queue at the edge that accepts its push, and the back then
// loads the output register. A close of N bytes occupies the back one byte per
// cycle while pop is high; the front keeps taking items until the queue fills.
// Reset: word and fill are cleared, key_size returns to 8, bit_order to 1,
// the queue and output register are emptied (empty high, full low).
// Receiver stall: the result holds while pop is low; the back stops, the
// queue fills and full rises, then resumes at full rate once pop returns.
module variable_width_bit_packer #(
    parameter int QUEUE_DEPTH = vwbp_pkg::QUEUE_DEPTH   // 2 or more
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  vwbp_pkg::in_item_t               item,
    output logic                             empty,
    input  logic                             pop,
    output vwbp_pkg::out_item_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vwbp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vwbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vwbp_pkg::*;

    logic job_valid;
    job_t job;
    logic queue_full;
    logic rd_en;
    logic head_valid;
    job_t head_job;

    // Config writes are always taken; software is to write only while idle, and the block does not enforce this.
    assign cfg_ready = 1'b1;
    assign full      = queue_full;

    // Front: pack codes, classify into word jobs and flush jobs.
    vwbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .queue_full (queue_full),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job_valid  (job_valid),
        .job        (job)
    );

    // Decouple the front from a stalled or flushing back.
    vwbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (job_valid),
        .wr_job     (job),
        .full       (queue_full),
        .rd_en      (rd_en),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: emit words, or walk a flush job byte by byte.
    vwbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .rd_en      (rd_en),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== rtl/vwbp_checker.sv =====
// Port-level checker for the bit packer, bound to the top level.
// Depends on vwbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vwbp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  logic                pop,
    input  vwbp_pkg::out_item_t result
);
    import vwbp_pkg::*;

    // Reset drains the result side.
    `VWBP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result pending after reset")

    // A stalled result holds.
    `VWBP_ASSERT(a_stall_hold, !empty && !pop |=> !empty && $stable(result), "result moved")

    // Only a flushed byte can close a flush.
    `VWBP_ASSERT(a_last_on_byte, !empty && result.out_last |-> result.out_kind == KIND_BYTE,
        "last flag on a word")

    // A flushed byte carries nothing above its low 8 bits.
    `VWBP_ASSERT(a_byte_clean,
        !empty && result.out_kind == KIND_BYTE |-> result.out_data[WORD_BITS-1:8] == '0,
        "flushed byte has high bits")

endmodule

bind variable_width_bit_packer vwbp_checker u_vwbp_checker (.*);
